/* src/tba_pkg.sv */
// Shared types, constants and width helpers for the track box association core.
package tba_pkg;

  localparam int MAX_TRACKS_DEF = 32;
  localparam int COORD_BITS_DEF = 13;

  localparam int SIZE_W  = 12;
  localparam int CONF_W  = 16;
  localparam int CLASS_W = 8;
  localparam int IDENT_W = 7;
  localparam int SLOT_W  = 5;
  localparam int POS_W   = 6;

  localparam logic [POS_W-1:0] POS_MAX = 6'd63;
  localparam int DIST_LIMIT = 32767;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } tba_state_e;

  // Attributes kept with each track entry.
  typedef struct packed {
    logic [CONF_W-1:0]  conf;
    logic [CLASS_W-1:0] cls;
    logic [IDENT_W-1:0] ident;
  } track_attr_t;

  // Entry write control, broadcast along the row.
  typedef struct packed {
    logic en;
    logic fresh;  // new entry: also load class and identifier
  } cell_wr_t;

  // Fixed part of the search word handed from cell to cell.
  typedef struct packed {
    logic               hit;
    logic [IDENT_W-1:0] ident;
  } tok_meta_t;

  // Signed working width for centres, edges and distances.
  function automatic int work_width(input int coord_bits);
    int sw;
    sw = ((coord_bits + 1 > SIZE_W + 1) ? coord_bits + 1 : SIZE_W + 1) + 1;
    return (sw + 1 > 16) ? sw + 1 : 16;
  endfunction

endpackage

/* src/track_box_association_core.sv */
// Top level of the track box association core: control, frame state and the row of cells.
// Takes one detection at a time and returns one result word for it. A detection occupies
// the block from the cycle in which it is accepted and its box centre worked out, through
// the scan while the search word ripples through the row of cells, one entry per cycle,
// to the decision that writes the chosen entry back and loads the result register. The
// next detection is accepted in the cycle after the result is loaded, even while that result
// still waits to be taken; an earlier result still waiting at that point holds the block in
// its last cycle. The table holds MAX_TRACKS entries; when it is full a detection that needs
// a new entry is discarded and flagged as dropped.
module track_box_association_core #(
  parameter int MAX_TRACKS = tba_pkg::MAX_TRACKS_DEF,
  parameter int COORD_BITS = tba_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              frame_first_i,
  input  logic signed [COORD_BITS-1:0]      box_left_i,
  input  logic signed [COORD_BITS-1:0]      box_top_i,
  input  logic [tba_pkg::SIZE_W-1:0]        box_width_i,
  input  logic [tba_pkg::SIZE_W-1:0]        box_height_i,
  input  logic [tba_pkg::CLASS_W-1:0]       class_id_i,
  input  logic [tba_pkg::CONF_W-1:0]        confidence_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tba_pkg::SLOT_W-1:0]        slot_o,
  output logic [tba_pkg::IDENT_W-1:0]       object_id_o,
  output logic                              matched_o,
  output logic                              dropped_o
);

  localparam int WW   = tba_pkg::work_width(COORD_BITS);
  localparam int IW   = $clog2(MAX_TRACKS);
  localparam int CNTW = $clog2(MAX_TRACKS + 1);

  tba_pkg::tba_state_e state_q, state_d;
  logic [IW-1:0]       scan_cnt_q, scan_cnt_d;
  logic [CNTW-1:0]     count_q;
  logic                empty_q;
  logic [tba_pkg::POS_W-1:0] pos_q, item_pos_q, pos_cur;
  logic                empty_cur;

  logic signed [WW-1:0] det_left_q, det_right_q, det_top_q, det_bottom_q;
  logic signed [WW-1:0] det_cx_q, det_cy_q;
  logic [tba_pkg::CONF_W-1:0]  det_conf_q;
  logic [tba_pkg::CLASS_W-1:0] det_cls_q;

  logic out_valid_q;
  logic [tba_pkg::SLOT_W-1:0]  slot_q;
  logic [tba_pkg::IDENT_W-1:0] ident_q;
  logic matched_q, dropped_q;

  logic in_acc, fire;

  // Centre and far edges of the incoming box.
  logic signed [WW-1:0] lx, ly, wx, hy, sx, sy, cx_new, cy_new;

  always_comb begin
    lx = WW'(box_left_i);
    ly = WW'(box_top_i);
    wx = $signed(WW'(box_width_i));
    hy = $signed(WW'(box_height_i));
    sx = (lx <<< 1) + wx;
    sy = (ly <<< 1) + hy;
    // Halve and round half to even: bump an odd floor when the sum is odd.
    cx_new = (sx >>> 1) + $signed({{(WW-1){1'b0}}, sx[0] & sx[1]});
    cy_new = (sy >>> 1) + $signed({{(WW-1){1'b0}}, sy[0] & sy[1]});
  end

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != tba_pkg::ST_IDLE);
  assign fire      = (state_q == tba_pkg::ST_DECIDE) && (!out_valid_q || !out_stall_i);

  assign pos_cur   = frame_first_i ? '0 : pos_q;
  assign empty_cur = frame_first_i ? (count_q == '0) : empty_q;

  // Search word chain: position 0 is the start word, position MAX_TRACKS the verdict.
  logic [WW-1:0]      tok_best [MAX_TRACKS+1];
  logic [IW-1:0]      tok_idx  [MAX_TRACKS+1];
  tba_pkg::tok_meta_t tok_meta [MAX_TRACKS+1];

  assign tok_best[0] = WW'(tba_pkg::DIST_LIMIT);
  assign tok_idx[0]  = '0;
  assign tok_meta[0] = '0;

  tba_pkg::cell_wr_t    wr;
  logic [IW-1:0]        wr_idx;
  tba_pkg::track_attr_t wr_attr;
  logic [tba_pkg::IDENT_W-1:0] res_ident;
  logic res_matched, res_dropped;

  always_comb begin
    wr          = '0;
    wr_idx      = '0;
    res_ident   = '0;
    res_matched = 1'b0;
    res_dropped = 1'b0;
    if (tok_meta[MAX_TRACKS].hit) begin
      wr.en       = fire;
      wr_idx      = tok_idx[MAX_TRACKS];
      res_ident   = tok_meta[MAX_TRACKS].ident;
      res_matched = 1'b1;
    end else if (count_q != CNTW'(MAX_TRACKS)) begin
      wr.en    = fire;
      wr.fresh = 1'b1;
      wr_idx   = IW'(count_q);
      res_ident = empty_q ? tba_pkg::IDENT_W'(item_pos_q)
                          : tba_pkg::IDENT_W'(count_q) + 1'b1;
    end else begin
      res_dropped = 1'b1;
    end
    wr_attr.conf  = det_conf_q;
    wr_attr.cls   = det_cls_q;
    wr_attr.ident = res_ident;
  end

  for (genvar j = 0; j < MAX_TRACKS; j++) begin : g_cell
    tba_cell #(
      .MAX_TRACKS (MAX_TRACKS),
      .COORD_BITS (COORD_BITS),
      .IDX        (j)
    ) u_cell (
      .clk_i        (clk_i),
      .count_i      (count_q),
      .scan_en_i    (!empty_q),
      .det_left_i   (det_left_q),
      .det_right_i  (det_right_q),
      .det_top_i    (det_top_q),
      .det_bottom_i (det_bottom_q),
      .det_cx_i     (det_cx_q),
      .det_cy_i     (det_cy_q),
      .attr_i       (wr_attr),
      .wr_i         (wr),
      .wr_idx_i     (wr_idx),
      .best_i       (tok_best[j]),
      .idx_i        (tok_idx[j]),
      .meta_i       (tok_meta[j]),
      .best_o       (tok_best[j+1]),
      .idx_o        (tok_idx[j+1]),
      .meta_o       (tok_meta[j+1])
    );
  end

  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    case (state_q)
      tba_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d    = tba_pkg::ST_SCAN;
          scan_cnt_d = '0;
        end
      end
      tba_pkg::ST_SCAN: begin
        if (scan_cnt_q == IW'(MAX_TRACKS - 1)) begin
          state_d = tba_pkg::ST_DECIDE;
        end else begin
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
      end
      tba_pkg::ST_DECIDE: begin
        if (fire) begin
          state_d = tba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tba_pkg::ST_IDLE;
      scan_cnt_q  <= '0;
      count_q     <= '0;
      empty_q     <= 1'b1;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      if (in_acc) begin
        empty_q <= empty_cur;
        pos_q   <= (pos_cur < tba_pkg::POS_MAX) ? pos_cur + 1'b1 : pos_cur;
      end
      if (fire && wr.fresh) begin
        count_q <= count_q + 1'b1;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_pos_q   <= pos_cur;
      det_left_q   <= lx;
      det_top_q    <= ly;
      det_right_q  <= lx + wx;
      det_bottom_q <= ly + hy;
      det_cx_q     <= cx_new;
      det_cy_q     <= cy_new;
      det_conf_q   <= confidence_i;
      det_cls_q    <= class_id_i;
    end
    if (fire) begin
      slot_q    <= res_dropped ? '0 : tba_pkg::SLOT_W'(wr_idx);
      ident_q   <= res_ident;
      matched_q <= res_matched;
      dropped_q <= res_dropped;
    end
  end

  assign out_valid_o = out_valid_q;
  assign slot_o      = slot_q;
  assign object_id_o = ident_q;
  assign matched_o   = matched_q;
  assign dropped_o   = dropped_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(MAX_TRACKS))
    else $error("track count beyond table size");

  a_fire_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("result word not loaded after decision");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_o) |-> (!matched_o && count_q == CNTW'(MAX_TRACKS)))
    else $error("dropped word while table not full");

  a_match_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && tok_meta[MAX_TRACKS].hit) |=> $stable(count_q))
    else $error("matched update changed track count");
`endif

endmodule

/* src/tba_cell.sv */
// One track entry of the row: holds its centre and attributes, refines the search word.
module tba_cell #(
  parameter int MAX_TRACKS = tba_pkg::MAX_TRACKS_DEF,
  parameter int COORD_BITS = tba_pkg::COORD_BITS_DEF,
  parameter int IDX        = 0
) (
  input  logic                                          clk_i,
  input  logic [$clog2(MAX_TRACKS+1)-1:0]               count_i,
  input  logic                                          scan_en_i,
  input  logic signed [tba_pkg::work_width(COORD_BITS)-1:0] det_left_i,
  input  logic signed [tba_pkg::work_width(COORD_BITS)-1:0] det_right_i,
  input  logic signed [tba_pkg::work_width(COORD_BITS)-1:0] det_top_i,
  input  logic signed [tba_pkg::work_width(COORD_BITS)-1:0] det_bottom_i,
  input  logic signed [tba_pkg::work_width(COORD_BITS)-1:0] det_cx_i,
  input  logic signed [tba_pkg::work_width(COORD_BITS)-1:0] det_cy_i,
  input  tba_pkg::track_attr_t                          attr_i,
  input  tba_pkg::cell_wr_t                             wr_i,
  input  logic [$clog2(MAX_TRACKS)-1:0]                 wr_idx_i,
  input  logic [tba_pkg::work_width(COORD_BITS)-1:0]    best_i,
  input  logic [$clog2(MAX_TRACKS)-1:0]                 idx_i,
  input  tba_pkg::tok_meta_t                            meta_i,
  output logic [tba_pkg::work_width(COORD_BITS)-1:0]    best_o,
  output logic [$clog2(MAX_TRACKS)-1:0]                 idx_o,
  output tba_pkg::tok_meta_t                            meta_o
);

  localparam int WW   = tba_pkg::work_width(COORD_BITS);
  localparam int IW   = $clog2(MAX_TRACKS);
  localparam int CNTW = $clog2(MAX_TRACKS + 1);

  // The entry keeps its box as the centre, the only part the search reads.
  logic signed [WW-1:0] cx_q, cy_q;
  tba_pkg::track_attr_t attr_q;

  logic [WW-1:0]        best_q;
  logic [IW-1:0]        idx_q;
  tba_pkg::tok_meta_t   meta_q;

  logic                 active, in_box, hit;
  logic signed [WW-1:0] dx, dy;
  logic [WW-1:0]        adx, ady, near_dist;

  always_comb begin
    active    = scan_en_i && (CNTW'(IDX) < count_i);
    in_box    = (det_left_i <= cx_q) && (cx_q < det_right_i) &&
                (det_top_i <= cy_q) && (cy_q < det_bottom_i);
    dx        = det_cx_i - cx_q;
    dy        = det_cy_i - cy_q;
    adx       = dx[WW-1] ? WW'(-dx) : WW'(dx);
    ady       = dy[WW-1] ? WW'(-dy) : WW'(dy);
    near_dist = (adx > ady) ? adx : ady;
    // Strictly smaller only, so the lowest index keeps a tie.
    hit       = active && in_box && (near_dist < best_i);
  end

  always_ff @(posedge clk_i) begin
    best_q <= hit ? near_dist : best_i;
    idx_q  <= hit ? IW'(IDX) : idx_i;
    if (hit) begin
      meta_q.hit   <= 1'b1;
      meta_q.ident <= attr_q.ident;
    end else begin
      meta_q <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_idx_i == IW'(IDX))) begin
      cx_q        <= det_cx_i;
      cy_q        <= det_cy_i;
      attr_q.conf <= attr_i.conf;
      if (wr_i.fresh) begin
        attr_q.cls   <= attr_i.cls;
        attr_q.ident <= attr_i.ident;
      end
    end
  end

  assign best_o = best_q;
  assign idx_o  = idx_q;
  assign meta_o = meta_q;

endmodule
